// ----- rtl/fms_pkg.sv -----
package fms_pkg;

    localparam int TIMER_WIDTH_DEF = 32;
    localparam int REG_WIDTH       = 32;
    localparam int NUM_REGS        = 4;
    localparam int ADDR_WIDTH      = 4;

    localparam logic [REG_WIDTH-1:0] TIMEOUT_RESET = REG_WIDTH'(1000);

    localparam logic [1:0] REG_ARM_TIMEOUT    = 2'd0;
    localparam logic [1:0] REG_APOGEE_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_DEPLOY_TIMEOUT = 2'd2;
    localparam logic [1:0] REG_END_TIMEOUT    = 2'd3;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_EVENT = 1'b1;

    localparam logic [3:0] EV_BOOT_FAULT     = 4'd0;
    localparam logic [3:0] EV_BOOT_DONE      = 4'd1;
    localparam logic [3:0] EV_TEST_MODE      = 4'd2;
    localparam logic [3:0] EV_NOSE_LINK_LOST = 4'd3;
    localparam logic [3:0] EV_IGNITER_LOST   = 4'd4;
    localparam logic [3:0] EV_IGNITION_ABORT = 4'd5;
    localparam logic [3:0] EV_ARM            = 4'd6;
    localparam logic [3:0] EV_DISARM         = 4'd7;
    localparam logic [3:0] EV_LAUNCH         = 4'd8;
    localparam logic [3:0] EV_UMBILICAL      = 4'd9;
    localparam logic [3:0] EV_PEAK_REACHED   = 4'd10;
    localparam logic [3:0] EV_DPL_ALT        = 4'd11;
    localparam logic [3:0] EV_MANUAL         = 4'd12;
    localparam logic [3:0] EV_END_MISSION    = 4'd13;
    localparam logic [3:0] EV_BOARD_RESET    = 4'd14;
    localparam logic [3:0] EV_OTHER          = 4'd15;

    localparam logic [3:0] MODE_INIT     = 4'd0;
    localparam logic [3:0] MODE_TEST     = 4'd1;
    localparam logic [3:0] MODE_ERROR    = 4'd2;
    localparam logic [3:0] MODE_DISARMED = 4'd3;
    localparam logic [3:0] MODE_ARMED    = 4'd4;
    localparam logic [3:0] MODE_LAUNCH   = 4'd5;
    localparam logic [3:0] MODE_ASCEND   = 4'd6;
    localparam logic [3:0] MODE_DESC1    = 4'd7;
    localparam logic [3:0] MODE_DESC2    = 4'd8;
    localparam logic [3:0] MODE_MANUAL   = 4'd9;
    localparam logic [3:0] MODE_LANDED   = 4'd10;

    localparam logic [2:0] NOTE_NONE     = 3'd0;
    localparam logic [2:0] NOTE_ARMED    = 3'd1;
    localparam logic [2:0] NOTE_LIFTOFF  = 3'd2;
    localparam logic [2:0] NOTE_APOGEE   = 3'd3;
    localparam logic [2:0] NOTE_DPL_ALT  = 3'd4;
    localparam logic [2:0] NOTE_LANDED   = 3'd5;

    typedef struct packed {
        logic       opcode;
        logic [3:0] event_code;
    } t_in_word;

    typedef struct packed {
        logic [3:0] mode;
        logic       mode_changed;
        logic [2:0] notify;
        logic       handled;
    } t_out_word;

endpackage

// ----- rtl/flight_mode_sequencer.sv -----
// Flight mode sequencer: steps a vehicle through eleven modes from init to landed. Each input
// word is a timer tick or an external event, and each yields exactly one result word with the
// new mode, a changed flag, the entry notification and a handled flag. A result is computed in
// the cycle its input word is accepted and appears in the output register in the next cycle; the
// block takes one word per cycle while o_in_ready is high, and o_in_ready is high whenever the
// output register is empty or is being taken in the same cycle. The four timeout registers sit
// on an APB port and are loaded into the single countdown on entry to armed, ascending, first,
// second and manual descent; a new timeout only affects the next entry.
module flight_mode_sequencer
    import fms_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_word              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_word             o_out_word,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_WIDTH-1:0] paddr,
    input  logic [REG_WIDTH-1:0]  pwdata,
    output logic [REG_WIDTH-1:0]  prdata,
    output logic                  pready
);

    localparam logic [TIMER_WIDTH-1:0] TIMER_ONE = TIMER_WIDTH'(1);

    logic [REG_WIDTH-1:0]   r_timeout [NUM_REGS];
    logic [3:0]             r_mode;
    logic [3:0]             n_mode;
    logic [TIMER_WIDTH-1:0] r_countdown;
    logic [TIMER_WIDTH-1:0] n_countdown;
    logic                   r_active;
    logic                   n_active;
    logic                   r_out_valid;
    t_out_word              r_out_word;
    t_out_word              n_out_word;

    logic                   in_accept;
    logic                   cfg_write;
    logic [1:0]             reg_index;
    logic [3:0]             tgt_mode;
    logic [3:0]             event_tgt;
    logic [3:0]             timeout_tgt;
    logic                   tgt_timed;
    logic [2:0]             tgt_note;
    logic [REG_WIDTH-1:0]   load_raw;
    logic [TIMER_WIDTH-1:0] load_value;
    logic                   handled;
    logic                   changed;

    assign pready      = 1'b1;
    assign reg_index   = paddr[3:2];
    assign cfg_write   = psel && penable && pwrite;
    assign prdata      = r_timeout[reg_index];
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_comb begin
        event_tgt = r_mode;
        case (r_mode)
            MODE_INIT: begin
                if (i_in_word.event_code == EV_BOOT_FAULT) event_tgt = MODE_ERROR;
                if (i_in_word.event_code == EV_BOOT_DONE) event_tgt = MODE_DISARMED;
            end
            MODE_DISARMED: begin
                if (i_in_word.event_code == EV_TEST_MODE) event_tgt = MODE_TEST;
                if (i_in_word.event_code == EV_NOSE_LINK_LOST ||
                    i_in_word.event_code == EV_IGNITER_LOST ||
                    i_in_word.event_code == EV_IGNITION_ABORT) event_tgt = MODE_ERROR;
                if (i_in_word.event_code == EV_ARM) event_tgt = MODE_ARMED;
            end
            MODE_ARMED: begin
                if (i_in_word.event_code == EV_NOSE_LINK_LOST ||
                    i_in_word.event_code == EV_IGNITER_LOST ||
                    i_in_word.event_code == EV_IGNITION_ABORT) event_tgt = MODE_ERROR;
                if (i_in_word.event_code == EV_DISARM) event_tgt = MODE_DISARMED;
                if (i_in_word.event_code == EV_LAUNCH) event_tgt = MODE_LAUNCH;
            end
            MODE_LAUNCH: begin
                if (i_in_word.event_code == EV_UMBILICAL) event_tgt = MODE_ASCEND;
                if (i_in_word.event_code == EV_DISARM) event_tgt = MODE_DISARMED;
                if (i_in_word.event_code == EV_IGNITION_ABORT) event_tgt = MODE_ERROR;
            end
            MODE_ASCEND: begin
                if (i_in_word.event_code == EV_PEAK_REACHED) event_tgt = MODE_DESC1;
            end
            MODE_DESC1: begin
                if (i_in_word.event_code == EV_DPL_ALT) event_tgt = MODE_DESC2;
                if (i_in_word.event_code == EV_MANUAL) event_tgt = MODE_MANUAL;
            end
            MODE_DESC2, MODE_MANUAL: begin
                if (i_in_word.event_code == EV_END_MISSION) event_tgt = MODE_LANDED;
            end
            default: begin
                event_tgt = r_mode;
            end
        endcase
    end

    always_comb begin
        case (r_mode)
            MODE_ARMED:               timeout_tgt = MODE_DISARMED;
            MODE_ASCEND:              timeout_tgt = MODE_DESC1;
            MODE_DESC1:               timeout_tgt = MODE_DESC2;
            MODE_DESC2, MODE_MANUAL:  timeout_tgt = MODE_LANDED;
            default:                  timeout_tgt = r_mode;
        endcase
    end

    always_comb begin
        tgt_timed = 1'b1;
        tgt_note  = NOTE_NONE;
        load_raw  = r_timeout[REG_END_TIMEOUT];
        case (tgt_mode)
            MODE_ARMED: begin
                tgt_note = NOTE_ARMED;
                load_raw = r_timeout[REG_ARM_TIMEOUT];
            end
            MODE_ASCEND: begin
                tgt_note = NOTE_LIFTOFF;
                load_raw = r_timeout[REG_APOGEE_TIMEOUT];
            end
            MODE_DESC1: begin
                tgt_note = NOTE_APOGEE;
                load_raw = r_timeout[REG_DEPLOY_TIMEOUT];
            end
            MODE_DESC2: begin
                tgt_note = NOTE_DPL_ALT;
            end
            MODE_MANUAL: begin
                tgt_note = NOTE_NONE;
            end
            MODE_LANDED: begin
                tgt_note  = NOTE_LANDED;
                tgt_timed = 1'b0;
            end
            default: begin
                tgt_timed = 1'b0;
            end
        endcase
    end

    // A timeout wider than the countdown saturates to its largest value.
    generate
        if (TIMER_WIDTH >= REG_WIDTH) begin : g_load_wide
            assign load_value = TIMER_WIDTH'(load_raw);
        end else begin : g_load_narrow
            assign load_value = (|load_raw[REG_WIDTH-1:TIMER_WIDTH]) ?
                                {TIMER_WIDTH{1'b1}} : load_raw[TIMER_WIDTH-1:0];
        end
    endgenerate

    always_comb begin
        tgt_mode    = r_mode;
        handled     = 1'b0;
        n_countdown = r_countdown;
        n_active    = r_active;
        if (i_in_word.opcode == OP_TICK) begin
            if (r_active) begin
                if (r_countdown <= TIMER_ONE) begin
                    tgt_mode    = timeout_tgt;
                    handled     = 1'b1;
                    n_countdown = '0;
                    n_active    = 1'b0;
                end else begin
                    n_countdown = r_countdown - TIMER_ONE;
                end
            end
        end else begin
            tgt_mode = event_tgt;
            if (event_tgt != r_mode) begin
                handled = 1'b1;
            end else if (i_in_word.event_code == EV_BOARD_RESET &&
                         (r_mode == MODE_TEST || r_mode == MODE_ERROR)) begin
                handled = 1'b1;
            end
        end
        changed = (tgt_mode != r_mode);
        n_mode  = tgt_mode;
        if (changed) begin
            n_active    = tgt_timed;
            n_countdown = tgt_timed ? load_value : '0;
        end
        n_out_word.mode         = tgt_mode;
        n_out_word.mode_changed = changed;
        n_out_word.notify       = changed ? tgt_note : NOTE_NONE;
        n_out_word.handled      = handled;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_INIT;
            r_countdown <= '0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_REGS; i++) begin
                r_timeout[i] <= TIMEOUT_RESET;
            end
        end else begin
            if (cfg_write) begin
                r_timeout[reg_index] <= pwdata;
            end
            if (in_accept) begin
                r_mode      <= n_mode;
                r_countdown <= n_countdown;
                r_active    <= n_active;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_word <= n_out_word;
        end
    end

endmodule

// ----- rtl/fms_checker.sv -----
module fms_checker
    import fms_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out_word
);

    a_notify_needs_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.notify != NOTE_NONE) |-> o_out_word.mode_changed)
        else $error("Notification raised without a mode change.");

    a_change_is_handled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.mode_changed) |-> o_out_word.handled)
        else $error("Mode change reported as not handled.");

    a_landed_note: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.notify == NOTE_LANDED) |-> o_out_word.mode == MODE_LANDED)
        else $error("Landed notification outside landed mode.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_word)))
        else $error("Stalled result word dropped or changed.");

endmodule

bind flight_mode_sequencer fms_checker u_fms_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);

// ----- sim/flight_mode_sequencer_test.sv -----
module flight_mode_sequencer_test
    import fms_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 4000;

    typedef struct packed {
        logic [3:0]  mode;
        logic [31:0] count;
        logic        timer_on;
    } t_seq_state;

    typedef struct packed {
        t_seq_state nxt;
        t_out_word  res;
    } t_step;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_word              i_in_word = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_word             o_out_word;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [ADDR_WIDTH-1:0] paddr = '0;
    logic [REG_WIDTH-1:0]  pwdata = '0;
    logic [REG_WIDTH-1:0]  prdata;
    logic                  pready;

    logic [31:0] tick_limit [NUM_REGS];
    t_seq_state  seq_state;
    t_seq_state  plan_state;
    t_step       accepted_step;
    t_out_word   report_due;
    t_out_word   due_reports [$];
    t_in_word    word_backlog [$];
    logic [3:0]  final_mode;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          mismatches = 0;
    int          quiet_cycles = 0;

    flight_mode_sequencer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [3:0] event_mode(logic [3:0] m, logic [3:0] ev);
        case (m)
            MODE_INIT: begin
                if (ev == EV_BOOT_FAULT) return MODE_ERROR;
                if (ev == EV_BOOT_DONE) return MODE_DISARMED;
            end
            MODE_DISARMED: begin
                if (ev == EV_TEST_MODE) return MODE_TEST;
                if (ev == EV_NOSE_LINK_LOST || ev == EV_IGNITER_LOST ||
                    ev == EV_IGNITION_ABORT)
                    return MODE_ERROR;
                if (ev == EV_ARM) return MODE_ARMED;
            end
            MODE_ARMED: begin
                if (ev == EV_NOSE_LINK_LOST || ev == EV_IGNITER_LOST ||
                    ev == EV_IGNITION_ABORT)
                    return MODE_ERROR;
                if (ev == EV_DISARM) return MODE_DISARMED;
                if (ev == EV_LAUNCH) return MODE_LAUNCH;
            end
            MODE_LAUNCH: begin
                if (ev == EV_UMBILICAL) return MODE_ASCEND;
                if (ev == EV_DISARM) return MODE_DISARMED;
                if (ev == EV_IGNITION_ABORT) return MODE_ERROR;
            end
            MODE_ASCEND: begin
                if (ev == EV_PEAK_REACHED) return MODE_DESC1;
            end
            MODE_DESC1: begin
                if (ev == EV_DPL_ALT) return MODE_DESC2;
                if (ev == EV_MANUAL) return MODE_MANUAL;
            end
            MODE_DESC2, MODE_MANUAL: begin
                if (ev == EV_END_MISSION) return MODE_LANDED;
            end
            default: begin
            end
        endcase
        return m;
    endfunction

    function automatic logic [3:0] timeout_mode(logic [3:0] m);
        case (m)
            MODE_ARMED:              return MODE_DISARMED;
            MODE_ASCEND:             return MODE_DESC1;
            MODE_DESC1:              return MODE_DESC2;
            MODE_DESC2, MODE_MANUAL: return MODE_LANDED;
            default:                 return m;
        endcase
    endfunction

    function automatic t_step flight_step(t_seq_state s, t_in_word w);
        t_step      r;
        logic [3:0] tgt;
        r     = '0;
        r.nxt = s;
        tgt   = s.mode;
        if (w.opcode == OP_TICK) begin
            if (s.timer_on) begin
                if (s.count <= 32'd1) begin
                    r.nxt.count     = '0;
                    r.nxt.timer_on  = 1'b0;
                    r.res.handled   = 1'b1;
                    tgt             = timeout_mode(s.mode);
                end else begin
                    r.nxt.count = s.count - 32'd1;
                end
            end
        end else begin
            tgt = event_mode(s.mode, w.event_code);
            if (tgt != s.mode) begin
                r.res.handled = 1'b1;
            end else if (w.event_code == EV_BOARD_RESET &&
                         (s.mode == MODE_TEST || s.mode == MODE_ERROR)) begin
                r.res.handled = 1'b1;
            end
        end
        if (tgt != s.mode) begin
            r.res.mode_changed = 1'b1;
            r.nxt.mode         = tgt;
            r.nxt.count        = '0;
            r.nxt.timer_on     = 1'b0;
            case (tgt)
                MODE_ARMED: begin
                    r.res.notify   = NOTE_ARMED;
                    r.nxt.count    = tick_limit[REG_ARM_TIMEOUT];
                    r.nxt.timer_on = 1'b1;
                end
                MODE_ASCEND: begin
                    r.res.notify   = NOTE_LIFTOFF;
                    r.nxt.count    = tick_limit[REG_APOGEE_TIMEOUT];
                    r.nxt.timer_on = 1'b1;
                end
                MODE_DESC1: begin
                    r.res.notify   = NOTE_APOGEE;
                    r.nxt.count    = tick_limit[REG_DEPLOY_TIMEOUT];
                    r.nxt.timer_on = 1'b1;
                end
                MODE_DESC2: begin
                    r.res.notify   = NOTE_DPL_ALT;
                    r.nxt.count    = tick_limit[REG_END_TIMEOUT];
                    r.nxt.timer_on = 1'b1;
                end
                MODE_MANUAL: begin
                    r.nxt.count    = tick_limit[REG_END_TIMEOUT];
                    r.nxt.timer_on = 1'b1;
                end
                MODE_LANDED: begin
                    r.res.notify = NOTE_LANDED;
                end
                default: begin
                end
            endcase
        end
        r.res.mode = r.nxt.mode;
        return r;
    endfunction

    function automatic bit mode_allowed(logic [3:0] m, bit last_leg);
        bit ground;
        ground = (m == MODE_DISARMED || m == MODE_ARMED || m == MODE_LAUNCH);
        if (!last_leg) return ground;
        if (final_mode == MODE_LANDED) return !(m == MODE_ERROR || m == MODE_TEST);
        return ground || m == final_mode;
    endfunction

    function automatic t_in_word choose_word(t_seq_state s, bit last_leg);
        t_in_word w;
        int       r;
        w.opcode     = 1'($urandom_range(0, 1));
        w.event_code = 4'($urandom_range(0, 15));
        r            = $urandom_range(0, 9);
        if ($urandom_range(0, 99) < 75) begin
            w.opcode = OP_EVENT;
            case (s.mode)
                MODE_INIT: w.event_code = EV_BOOT_DONE;
                MODE_DISARMED: begin
                    if (last_leg && final_mode == MODE_TEST)
                        w.event_code = EV_TEST_MODE;
                    else if (last_leg && final_mode == MODE_ERROR && r < 5)
                        w.event_code = EV_NOSE_LINK_LOST + 4'($urandom_range(0, 2));
                    else
                        w.event_code = EV_ARM;
                end
                MODE_ARMED: begin
                    if (r < (last_leg ? 3 : 4))
                        w.opcode = OP_TICK;
                    else if (r < (last_leg ? 4 : 6))
                        w.event_code = EV_DISARM;
                    else if (last_leg && final_mode == MODE_ERROR)
                        w.event_code = EV_NOSE_LINK_LOST + 4'($urandom_range(0, 2));
                    else
                        w.event_code = EV_LAUNCH;
                end
                MODE_LAUNCH: begin
                    if (!last_leg)
                        w.event_code = EV_DISARM;
                    else if (final_mode == MODE_ERROR)
                        w.event_code = EV_IGNITION_ABORT;
                    else
                        w.event_code = EV_UMBILICAL;
                end
                MODE_ASCEND: begin
                    if (r < 6) w.opcode = OP_TICK;
                    else w.event_code = EV_PEAK_REACHED;
                end
                MODE_DESC1: begin
                    if (r < 6) w.opcode = OP_TICK;
                    else if (r < 8) w.event_code = EV_DPL_ALT;
                    else w.event_code = EV_MANUAL;
                end
                MODE_DESC2, MODE_MANUAL: begin
                    if (r < 6) w.opcode = OP_TICK;
                    else w.event_code = EV_END_MISSION;
                end
                default: begin
                    if (r < 3) w.event_code = EV_BOARD_RESET;
                    else w.opcode = 1'($urandom_range(0, 1));
                end
            endcase
        end
        return w;
    endfunction

    task automatic push_word(t_in_word w);
        t_step s;
        s          = flight_step(plan_state, w);
        plan_state = s.nxt;
        word_backlog.push_back(w);
    endtask

    task automatic push_event(logic [3:0] ev);
        t_in_word w;
        w.opcode     = OP_EVENT;
        w.event_code = ev;
        push_word(w);
    endtask

    task automatic queue_leg(int n, bit last_leg);
        t_in_word w;
        t_step    s;
        int       useful;
        int       tries;
        bit       stuck;
        useful = 0;
        tries  = 0;
        while (useful < n && tries < 4 * n) begin
            w = choose_word(plan_state, last_leg);
            s = flight_step(plan_state, w);
            if (!mode_allowed(s.nxt.mode, last_leg)) begin
                w.opcode = OP_TICK;
                s        = flight_step(plan_state, w);
                if (!mode_allowed(s.nxt.mode, last_leg)) begin
                    w.opcode     = OP_EVENT;
                    w.event_code = EV_OTHER;
                    s            = flight_step(plan_state, w);
                end
            end
            stuck = (plan_state.mode == MODE_LANDED || plan_state.mode == MODE_ERROR ||
                     plan_state.mode == MODE_TEST);
            if (s.res.handled || (w.opcode == OP_TICK && plan_state.timer_on) || stuck)
                useful++;
            tries++;
            plan_state = s.nxt;
            word_backlog.push_back(w);
        end
    endtask

    task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch in %s: expected %0h, got %0h", what, want, got);
    endtask

    task automatic reg_access(logic [1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_WIDTH'({idx, 2'b00});
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        tick_limit[idx] = val;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== tick_limit[idx])
            flag_mismatch("register readback", tick_limit[idx], prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_drained();
        while (word_backlog.size() != 0 || i_in_valid || due_reports.size() != 0)
            @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                accepted_step = flight_step(seq_state, i_in_word);
                seq_state     = accepted_step.nxt;
                due_reports.push_back(accepted_step.res);
            end
            if (!i_in_valid || o_in_ready) begin
                if (word_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_word  <= word_backlog.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_reports.size() == 0) begin
                flag_mismatch("unexpected result word", '0, 32'(o_out_word));
            end else begin
                report_due = due_reports.pop_front();
                if (o_out_word.mode !== report_due.mode)
                    flag_mismatch("mode", report_due.mode, o_out_word.mode);
                if (o_out_word.mode_changed !== report_due.mode_changed)
                    flag_mismatch("mode_changed", report_due.mode_changed,
                                  o_out_word.mode_changed);
                if (o_out_word.notify !== report_due.notify)
                    flag_mismatch("notify", report_due.notify, o_out_word.notify);
                if (o_out_word.handled !== report_due.handled)
                    flag_mismatch("handled", report_due.handled, o_out_word.handled);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int          p;
        int          r;
        logic [31:0] arm_val;
        logic [31:0] other_val;
        t_in_word    w;

        for (p = 0; p < NUM_REGS; p++)
            tick_limit[p] = TIMEOUT_RESET;
        seq_state  = '0;
        plan_state = '0;
        r = $urandom_range(0, 5);
        final_mode = (r == 0) ? MODE_ERROR : (r == 1) ? MODE_TEST : MODE_LANDED;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The sequence opens in init, where everything except the two init events is ignored.
        w.opcode     = OP_TICK;
        w.event_code = 4'($urandom_range(0, 15));
        push_word(w);
        for (p = EV_TEST_MODE; p <= EV_OTHER; p++)
            push_event(4'(p));
        push_event(EV_BOOT_DONE);
        push_event(EV_BOARD_RESET);
        push_event(EV_OTHER);
        push_event(EV_ARM);
        w.event_code = 4'($urandom_range(0, 15));
        push_word(w);
        push_event(EV_LAUNCH);
        push_event(EV_DISARM);
        push_event(EV_ARM);
        push_event(EV_DISARM);
        wait_drained();

        for (p = 1; p <= 8; p++) begin
            case (p)
                1:       arm_val = 32'd1;
                2:       arm_val = 32'd0;
                3:       arm_val = 32'hFFFF_FFFF;
                4:       arm_val = $urandom_range(2, 9);
                5:       arm_val = $urandom_range(1, 5);
                6:       arm_val = $urandom();
                7:       arm_val = $urandom_range(1, 12);
                default: arm_val = $urandom_range(1, 4);
            endcase
            reg_access(REG_ARM_TIMEOUT, arm_val);
            if (p < 8) begin
                other_val = (p == 1) ? 32'd0 : (p == 2) ? 32'hFFFF_FFFF : $urandom();
                reg_access(REG_APOGEE_TIMEOUT, other_val);
                reg_access(REG_DEPLOY_TIMEOUT, ~other_val);
                reg_access(REG_END_TIMEOUT, other_val);
            end else begin
                reg_access(REG_APOGEE_TIMEOUT,
                           ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom_range(0, 6));
                reg_access(REG_DEPLOY_TIMEOUT,
                           ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom_range(0, 6));
                reg_access(REG_END_TIMEOUT,
                           ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom_range(0, 6));
            end
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 76; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 76; end
                default: begin send_idle_pct = 15; stall_pct = 15; end
            endcase
            queue_leg((p == 8) ? 130 : 128, p == 8);
            wait_drained();
        end

        repeat (3) @(posedge i_clk);
        if (mismatches == 0 && due_reports.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
